@@ rtl/core/wwvs_pkg.sv @@
// shared types and constants of the weighted window volume sums core
package wwvs_pkg;

  localparam int unsigned VOL_W = 32;
  localparam int unsigned BUY_W = 39;
  localparam int unsigned REF_W = 38;
  localparam int unsigned DELTA_W = 40;

  localparam int unsigned SHORT_WINDOW_DEF = 10;
  localparam int unsigned LONG_WINDOW_DEF = 60;

  // scale applied to the ask and bid window sums
  localparam int unsigned SCALE = 6;

  typedef struct packed {
    logic [VOL_W-1:0] ask_volume;
    logic [VOL_W-1:0] bid_volume;
    logic [VOL_W-1:0] total_volume;
  } bar_t;

  typedef struct packed {
    logic [BUY_W-1:0]          buyers_sum;
    logic [BUY_W-1:0]          sellers_sum;
    logic [REF_W-1:0]          reference_sum;
    logic [BUY_W-1:0]          extreme_buy;
    logic signed [DELTA_W-1:0] extreme_sell;
    logic signed [DELTA_W-1:0] buy_sell_delta;
  } sums_t;

endpackage

@@ rtl/core/weighted_window_volume_sums_core.sv @@
// top level of the weighted window volume sums core
// Takes one bar (ask, bid and total volume) per request and returns one result per bar:
// six times (twice the current value plus the previous SHORT_WINDOW-1 values) for ask
// and bid, twice the current plus the previous LONG_WINDOW-1 values for total volume,
// the extreme buy and sell values and the buyer minus seller difference. The block
// sustains one bar per cycle while the output is not stalled; a bar's result passes
// through the three register stages (window update at the taking edge, then scaling,
// then compare and subtract) before it is offered.
// History lives in chains of cells that shift once per bar and starts out cleared, so
// bars before the first one count as zero. Each stage advances on its own when the
// stage after it has room, so bubbles close up and in_stall_o rises only when all
// three stages are full and the output is stalled.
module weighted_window_volume_sums_core #(
  parameter int unsigned SHORT_WINDOW = wwvs_pkg::SHORT_WINDOW_DEF,
  parameter int unsigned LONG_WINDOW  = wwvs_pkg::LONG_WINDOW_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wwvs_pkg::bar_t  in_bar_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wwvs_pkg::sums_t out_sums_o
);

  localparam int unsigned SHORT_SUM_W = wwvs_pkg::VOL_W + $clog2(SHORT_WINDOW + 1);
  localparam int unsigned LONG_SUM_W  = wwvs_pkg::VOL_W + $clog2(LONG_WINDOW + 1);
  localparam int unsigned BUY_W   = wwvs_pkg::BUY_W;
  localparam int unsigned REF_W   = wwvs_pkg::REF_W;
  localparam int unsigned DELTA_W = wwvs_pkg::DELTA_W;

  // stage valid flags
  logic v1_q, v2_q, v3_q;
  logic out_free, s2_free, s1_free, load1;

  // stage 1: weighted window sums
  logic [SHORT_SUM_W-1:0] ask_w, bid_w;
  logic [LONG_SUM_W-1:0]  vol_w;

  // stage 2: scaled sums
  logic [BUY_W-1:0] buyers_q, sellers_q, buyers_d, sellers_d;
  logic [REF_W-1:0] ref_q;

  // stage 3: result register
  wwvs_pkg::sums_t out_q, out_d;
  logic [DELTA_W-1:0] neg_sellers;

  // a stage may load when it is empty or its contents move on this cycle
  assign out_free   = !v3_q || !out_stall_i;
  assign s2_free    = !v2_q || out_free;
  assign s1_free    = !v1_q || s2_free;
  assign in_stall_o = !s1_free;
  assign load1      = in_valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= in_valid_i;
      end
      if (s2_free) begin
        v2_q <= v1_q;
      end
      if (out_free) begin
        v3_q <= v2_q;
      end
    end
  end

  // window chains, one per channel, shifting once per accepted bar
  wwvs_window #(.DEPTH(SHORT_WINDOW - 1)) u_ask (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (load1),
    .vol_i      (in_bar_i.ask_volume),
    .weighted_o (ask_w)
  );

  wwvs_window #(.DEPTH(SHORT_WINDOW - 1)) u_bid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (load1),
    .vol_i      (in_bar_i.bid_volume),
    .weighted_o (bid_w)
  );

  wwvs_window #(.DEPTH(LONG_WINDOW - 1)) u_vol (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (load1),
    .vol_i      (in_bar_i.total_volume),
    .weighted_o (vol_w)
  );

  // scale ask and bid sums, wrapping at the output width
  assign buyers_d  = BUY_W'(ask_w) * BUY_W'(wwvs_pkg::SCALE);
  assign sellers_d = BUY_W'(bid_w) * BUY_W'(wwvs_pkg::SCALE);

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      buyers_q  <= buyers_d;
      sellers_q <= sellers_d;
      ref_q     <= REF_W'(vol_w);
    end
  end

  // compare against the reference, a tie gives zero
  assign neg_sellers = DELTA_W'(0) - DELTA_W'(sellers_q);

  always_comb begin
    out_d.buyers_sum     = buyers_q;
    out_d.sellers_sum    = sellers_q;
    out_d.reference_sum  = ref_q;
    out_d.extreme_buy    = (buyers_q > BUY_W'(ref_q)) ? buyers_q : '0;
    out_d.extreme_sell   = (sellers_q > BUY_W'(ref_q)) ? neg_sellers : '0;
    out_d.buy_sell_delta = DELTA_W'(buyers_q) - DELTA_W'(sellers_q);
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_sums_o  = out_q;

`ifndef ASSERT_OFF
  // input is held off only when every stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // extreme buy is either zero or the buyers sum above the reference
  a_ext_buy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_sums_o.extreme_buy == '0) ||
                     ((out_sums_o.extreme_buy == out_sums_o.buyers_sum) &&
                      (out_sums_o.buyers_sum > BUY_W'(out_sums_o.reference_sum)))))
    else $error("extreme buy inconsistent with sums");

  // a nonzero extreme sell needs sellers above the reference
  a_ext_sell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_sums_o.extreme_sell != '0)) |->
      (out_sums_o.sellers_sum > BUY_W'(out_sums_o.reference_sum)))
    else $error("extreme sell without sellers above reference");
`endif

endmodule

@@ rtl/core/wwvs_cell.sv @@
// one history cell: holds a volume and hands it to the next cell on each request
module wwvs_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [wwvs_pkg::VOL_W-1:0] data_i,
  output logic [wwvs_pkg::VOL_W-1:0] data_o
);

  logic [wwvs_pkg::VOL_W-1:0] data_q;

  // history starts cleared so bars before the start count as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/wwvs_window.sv @@
// sliding window: chain of history cells, running total and weighted sum register
module wwvs_window #(
  parameter int unsigned DEPTH = wwvs_pkg::SHORT_WINDOW_DEF - 1,
  localparam int unsigned SUM_W = wwvs_pkg::VOL_W + $clog2(DEPTH + 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [wwvs_pkg::VOL_W-1:0] vol_i,
  output logic [SUM_W-1:0]           weighted_o
);

  logic [wwvs_pkg::VOL_W-1:0] chain [DEPTH];
  logic [SUM_W-1:0]           total_q, total_d;
  logic [SUM_W-1:0]           weighted_q, weighted_d;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      wwvs_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en_i),
        .data_i (vol_i),
        .data_o (chain[k])
      );
    end else begin : g_body
      wwvs_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en_i),
        .data_i (chain[k-1]),
        .data_o (chain[k])
      );
    end
  end

  // twice the current value plus the held history
  assign weighted_d = SUM_W'({vol_i, 1'b0}) + total_q;
  // oldest value leaves the window, current one enters
  assign total_d = total_q - SUM_W'(chain[DEPTH-1]) + SUM_W'(vol_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en_i) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weighted_q <= weighted_d;
    end
  end

  assign weighted_o = weighted_q;

endmodule
